[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shorthand for clocked assertions with a disable iff reset guard
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define MRC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrc assertion failed");

// consequent checked in the cycle after the antecedent
`define MRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrc assertion failed");

`endif

[rtl/mrc_pkg.sv]
// ----------------------------------------------------------------------------
// mrc_pkg
// widths, operation codes and register indexes of the mixed-radix converter
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int DIGITS      = 4;
  localparam int DIGIT_WIDTH = 8;
  localparam int DIN_W       = DIGIT_WIDTH;
  localparam int DOUT_W      = DIGIT_WIDTH + 1;
  localparam int NUM_W       = 32;
  localparam int COUNT_W     = 3;
  localparam int IDX_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CFG_IDX_W   = $clog2(DIGITS + 1);
  localparam int CFG_DATA_W  = (DOUT_W > COUNT_W) ? DOUT_W : COUNT_W;
  localparam int BIT_CNT_W   = $clog2(NUM_W);

  localparam logic [DOUT_W-1:0] RADIX_MAX = DOUT_W'(1) << DIGIT_WIDTH;

  typedef enum logic [1:0] {
    FUNC_PACK   = 2'd0,
    FUNC_UNPACK = 2'd1,
    FUNC_INC    = 2'd2,
    FUNC_CHECK  = 2'd3
  } func_t;

  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_0     = CFG_IDX_W'(1);

endpackage

[rtl/mrc_channels.sv]
// ----------------------------------------------------------------------------
// mrc channels
// valid/ready channels for the converter's input and result words
// ----------------------------------------------------------------------------
interface mrc_in_if;
  import mrc_pkg::*;

  logic              valid;
  logic              ready;
  func_t             func;
  logic [NUM_W-1:0]  number_in;
  logic [DIN_W-1:0]  digit_in_0;
  logic [DIN_W-1:0]  digit_in_1;
  logic [DIN_W-1:0]  digit_in_2;
  logic [DIN_W-1:0]  digit_in_3;

  modport source (output valid, func, number_in, digit_in_0, digit_in_1, digit_in_2,
                  digit_in_3, input ready);
  modport sink   (input valid, func, number_in, digit_in_0, digit_in_1, digit_in_2,
                  digit_in_3, output ready);
endinterface

interface mrc_out_if;
  import mrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [NUM_W-1:0]  number_out;
  logic [DOUT_W-1:0] digit_out_0;
  logic [DOUT_W-1:0] digit_out_1;
  logic [DOUT_W-1:0] digit_out_2;
  logic [DOUT_W-1:0] digit_out_3;
  logic              all_maximal;
  logic              out_of_range;

  modport source (output valid, number_out, digit_out_0, digit_out_1, digit_out_2,
                  digit_out_3, all_maximal, out_of_range, input ready);
  modport sink   (input valid, number_out, digit_out_0, digit_out_1, digit_out_2,
                  digit_out_3, all_maximal, out_of_range, output ready);
endinterface

[rtl/mixed_radix_converter.sv]
// ----------------------------------------------------------------------------
// mixed_radix_converter
// packs, unpacks, increments and checks digit vectors over configurable radices
// ----------------------------------------------------------------------------
// usage
//   in_ch takes one word: func, number_in and four digits; out_ch returns one
//   result word per input word. cfg_we/cfg_index/cfg_data write digit_count
//   (index 0) and radix_0..radix_3 (indexes 1..4); the user must write them
//   only while the block is idle, which the block itself does not enforce.
//   in_ch.ready is high only when no word is in progress; a word takes:
//     pack       one multiply step per digit above 0
//     unpack     the divider retires one quotient bit per cycle
//     increment  one step per carry, and one for the digit that takes the increment
//     check      no work step; the result is formed in the final step
//   The result register frees the input side: a new word may be accepted while
//   a result waits on out_ch; if the receiver stalls, the next result holds in
//   its final step until the register empties. Reset sets digit_count to 4 and
//   every radix to 2, and drops out_ch.valid.
// ----------------------------------------------------------------------------
module mixed_radix_converter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrc_pkg::CFG_DATA_W-1:0] cfg_data,
  mrc_in_if.sink                         in_ch,
  mrc_out_if.source                      out_ch
);
  import mrc_pkg::*;

  localparam int PROD_W = NUM_W + 2 + DOUT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PACK,
    S_DIV,
    S_INC,
    S_FIN
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] digit_count;
  logic [DOUT_W-1:0]  radix [DIGITS];
  func_t              func_r;
  logic [DIN_W-1:0]   dig [DIGITS];
  logic [NUM_W-1:0]   quo;
  logic [NUM_W:0]     acc;
  logic [DOUT_W-1:0]  rem;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [IDX_W-1:0]   idx;
  logic [DOUT_W-1:0]  res [DIGITS];

  logic               out_valid;
  logic [NUM_W-1:0]   number_o;
  logic [DOUT_W-1:0]  dout [DIGITS];
  logic               all_max_o;
  logic               oor_o;

  logic [DOUT_W-1:0]  eff_radix [DIGITS];
  logic [COUNT_W-1:0] len;
  logic [COUNT_W-1:0] len_m1;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   idx_up;
  logic               bad_digit;
  logic               all_top;
  logic [DOUT_W-1:0]  r_sel;
  logic [NUM_W+1:0]   sum_in;
  logic [PROD_W-1:0]  prod;
  logic [NUM_W:0]     acc_step;
  logic [NUM_W+1:0]   fin_sum;
  logic               fin_big;
  logic [DOUT_W-1:0]  trial;
  logic               ge;
  logic [DOUT_W-1:0]  rem_step;
  logic [DOUT_W-1:0]  inc_val;
  logic               top_oor;
  logic [DOUT_W-1:0]  top_clamp;
  logic               out_free;

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      if (radix[k] == '0) begin
        eff_radix[k] = DOUT_W'(1);
      end else if (radix[k] > RADIX_MAX) begin
        eff_radix[k] = RADIX_MAX;
      end else begin
        eff_radix[k] = radix[k];
      end
    end
    if (digit_count == '0) begin
      len = COUNT_W'(1);
    end else if (digit_count > COUNT_W'(DIGITS)) begin
      len = COUNT_W'(DIGITS);
    end else begin
      len = digit_count;
    end
    len_m1   = len - COUNT_W'(1);
    last_idx = len_m1[IDX_W-1:0];
    idx_up   = idx + IDX_W'(1);

    bad_digit = 1'b0;
    all_top   = 1'b1;
    for (int k = 0; k < DIGITS; k++) begin
      if (COUNT_W'(k) < len) begin
        if ({1'b0, dig[k]} >= eff_radix[k]) bad_digit = 1'b1;
        if ({1'b0, dig[k]} != eff_radix[k] - DOUT_W'(1)) all_top = 1'b0;
      end
    end

    // one radix read port shared by pack, unpack and increment
    r_sel = eff_radix[idx];

    // horner step, capped at 2^32 so the accumulator cannot wrap
    sum_in   = {1'b0, acc} + (NUM_W+2)'(dig[idx_up]);
    prod     = PROD_W'(sum_in) * PROD_W'(r_sel);
    acc_step = (|prod[PROD_W-1:NUM_W]) ? {1'b1, {NUM_W{1'b0}}} : {1'b0, prod[NUM_W-1:0]};
    fin_sum  = {1'b0, acc} + (NUM_W+2)'(dig[0]);
    fin_big  = |fin_sum[NUM_W+1:NUM_W];

    // restoring division, one quotient bit per cycle
    trial    = {rem[DOUT_W-2:0], quo[NUM_W-1]};
    ge       = trial >= r_sel;
    rem_step = ge ? trial - r_sel : trial;

    inc_val  = res[idx] + DOUT_W'(1);

    top_oor   = quo >= NUM_W'(r_sel);
    top_clamp = (|quo[NUM_W-1:DOUT_W]) ? {DOUT_W{1'b1}} : quo[DOUT_W-1:0];

    out_free = !out_valid || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      digit_count <= COUNT_W'(DIGITS);
      for (int k = 0; k < DIGITS; k++) radix[k] <= DOUT_W'(2);
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DIGIT_COUNT) begin
          digit_count <= cfg_data[COUNT_W-1:0];
        end else if (cfg_index >= REG_RADIX_0 &&
                     cfg_index < REG_RADIX_0 + CFG_IDX_W'(DIGITS)) begin
          radix[IDX_W'(cfg_index - REG_RADIX_0)] <= cfg_data[DOUT_W-1:0];
        end
      end

      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            func_r  <= in_ch.func;
            dig[0]  <= in_ch.digit_in_0;
            dig[1]  <= in_ch.digit_in_1;
            dig[2]  <= in_ch.digit_in_2;
            dig[3]  <= in_ch.digit_in_3;
            quo     <= in_ch.number_in;
            acc     <= '0;
            rem     <= '0;
            bit_cnt <= '0;
            // increment starts from the used input digits, everything else from zero
            res[0] <= (in_ch.func == FUNC_INC && COUNT_W'(0) < len) ?
                      DOUT_W'(in_ch.digit_in_0) : '0;
            res[1] <= (in_ch.func == FUNC_INC && COUNT_W'(1) < len) ?
                      DOUT_W'(in_ch.digit_in_1) : '0;
            res[2] <= (in_ch.func == FUNC_INC && COUNT_W'(2) < len) ?
                      DOUT_W'(in_ch.digit_in_2) : '0;
            res[3] <= (in_ch.func == FUNC_INC && COUNT_W'(3) < len) ?
                      DOUT_W'(in_ch.digit_in_3) : '0;
            case (in_ch.func)
              FUNC_PACK: begin
                idx   <= last_idx - IDX_W'(1);
                state <= (len == COUNT_W'(1)) ? S_FIN : S_PACK;
              end
              FUNC_UNPACK: begin
                idx   <= '0;
                state <= (len == COUNT_W'(1)) ? S_FIN : S_DIV;
              end
              FUNC_INC: begin
                idx    <= last_idx;
                state  <= S_INC;
              end
              default: begin
                idx   <= '0;
                state <= S_FIN;
              end
            endcase
          end
        end

        S_PACK: begin
          acc <= acc_step;
          if (idx == '0) begin
            state <= S_FIN;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end

        S_DIV: begin
          quo     <= {quo[NUM_W-2:0], ge};
          bit_cnt <= bit_cnt + BIT_CNT_W'(1);
          if (bit_cnt == BIT_CNT_W'(NUM_W - 1)) begin
            res[idx] <= rem_step;
            rem      <= '0;
            idx      <= idx_up;
            if (idx_up == last_idx) state <= S_FIN;
          end else begin
            rem <= rem_step;
          end
        end

        S_INC: begin
          // carry only on an exact hit of the radix
          if (inc_val == r_sel && idx != '0) begin
            res[idx] <= '0;
            idx      <= idx - IDX_W'(1);
          end else begin
            res[idx] <= inc_val;
            state    <= S_FIN;
          end
        end

        S_FIN: begin
          if (out_free) begin
            state     <= S_IDLE;
            number_o  <= (func_r == FUNC_PACK) ?
                         (fin_big ? {NUM_W{1'b1}} : fin_sum[NUM_W-1:0]) : '0;
            for (int k = 0; k < DIGITS; k++) begin
              dout[k] <= (func_r == FUNC_UNPACK && idx == IDX_W'(k)) ? top_clamp : res[k];
            end
            all_max_o <= (func_r == FUNC_CHECK) && all_top;
            case (func_r)
              FUNC_PACK:   oor_o <= fin_big || bad_digit;
              FUNC_UNPACK: oor_o <= top_oor;
              default:     oor_o <= bad_digit;
            endcase
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.number_out   = number_o;
  assign out_ch.digit_out_0  = dout[0];
  assign out_ch.digit_out_1  = dout[1];
  assign out_ch.digit_out_2  = dout[2];
  assign out_ch.digit_out_3  = dout[3];
  assign out_ch.all_maximal  = all_max_o;
  assign out_ch.out_of_range = oor_o;

endmodule

[rtl/mrc_checker.sv]
// ----------------------------------------------------------------------------
// mrc_checker
// port-level checks on the converter's handshake and result words
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mrc_pkg::NUM_W-1:0]   number_out,
  input logic [mrc_pkg::DOUT_W-1:0]  digit_out_0,
  input logic [mrc_pkg::DOUT_W-1:0]  digit_out_1,
  input logic [mrc_pkg::DOUT_W-1:0]  digit_out_2,
  input logic [mrc_pkg::DOUT_W-1:0]  digit_out_3,
  input logic                        all_maximal
);
  import mrc_pkg::*;

  logic digits_zero;
  assign digits_zero = (digit_out_0 == '0) && (digit_out_1 == '0) &&
                       (digit_out_2 == '0) && (digit_out_3 == '0);

  // one word at a time
  `MRC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // a result comes from the final step, never straight from the accept
  `MRC_ASSERT_NEXT(a_no_result_next, clk, rst, in_valid && in_ready, !$rose(out_valid))
  `MRC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(number_out))
  // a packed number never comes with digits
  `MRC_ASSERT_SAME(a_pack_no_digits, clk, rst, out_valid && number_out != '0, digits_zero && !all_maximal)
  // a check result carries flags only
  `MRC_ASSERT_SAME(a_check_flags_only, clk, rst, out_valid && all_maximal, digits_zero && number_out == '0)

endmodule

bind mixed_radix_converter mrc_checker u_mrc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .number_out  (out_ch.number_out),
  .digit_out_0 (out_ch.digit_out_0),
  .digit_out_1 (out_ch.digit_out_1),
  .digit_out_2 (out_ch.digit_out_2),
  .digit_out_3 (out_ch.digit_out_3),
  .all_maximal (out_ch.all_maximal)
);

[tb/tb_mixed_radix_converter.sv]
// ----------------------------------------------------------------------------
// tb_mixed_radix_converter
// self-checking bench: directed and random words over many radix settings,
// every result compared field by field with an in-bench conversion model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_mixed_radix_converter;
  import mrc_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int WORD_TARGET    = 1250;
  localparam int DRAIN_CYCLES   = 120;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int GAP_PERCENT    = 6;

  localparam longint unsigned NUM_MAX   = 64'hFFFF_FFFF;
  localparam longint unsigned DIGIT_SAT = (64'd1 << DOUT_W) - 1;

  typedef struct {
    func_t            func;
    logic [NUM_W-1:0] number;
    logic [DIN_W-1:0] digit [DIGITS];
  } conv_word_t;

  typedef struct {
    logic [NUM_W-1:0]  number;
    logic [DOUT_W-1:0] digit [DIGITS];
    logic              all_max;
    logic              oor;
  } conv_result_t;

  class mrc_scoreboard;
    logic [COUNT_W-1:0] count_reg;
    logic [DOUT_W-1:0]  radix_reg [DIGITS];
    conv_result_t       pending_results [$];
    int                 errors;

    function new();
      count_reg = COUNT_W'(DIGITS);
      foreach (radix_reg[k]) radix_reg[k] = DOUT_W'(2);
      errors = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_DIGIT_COUNT) begin
        count_reg = data[COUNT_W-1:0];
      end else if (int'(idx) >= int'(REG_RADIX_0) && int'(idx) < int'(REG_RADIX_0) + DIGITS) begin
        radix_reg[int'(idx) - int'(REG_RADIX_0)] = data[DOUT_W-1:0];
      end
    endfunction

    function int used_len();
      if (count_reg == 0) return 1;
      if (count_reg > DIGITS) return DIGITS;
      return int'(count_reg);
    endfunction

    function longint unsigned eff_radix(int k);
      if (radix_reg[k] == 0) return 1;
      if (radix_reg[k] > RADIX_MAX) return longint'(RADIX_MAX);
      return longint'(radix_reg[k]);
    endfunction

    function conv_result_t convert_word(conv_word_t w);
      longint unsigned d [DIGITS];
      longint unsigned r [DIGITS];
      longint unsigned s [DIGITS];
      longint unsigned acc;
      longint unsigned t;
      conv_result_t    e;
      int              len;
      int              k;
      int              i;
      bit              big;
      bit              bad;
      bit              top;
      len = used_len();
      big = 1'b0;
      bad = 1'b0;
      top = 1'b1;
      e.number  = '0;
      e.all_max = 1'b0;
      e.oor     = 1'b0;
      for (k = 0; k < DIGITS; k++) begin
        d[k] = w.digit[k];
        r[k] = eff_radix(k);
        s[k] = 0;
        e.digit[k] = '0;
        if (k < len) begin
          if (d[k] >= r[k]) bad = 1'b1;
          if (d[k] != r[k] - 1) top = 1'b0;
        end
      end
      case (w.func)
        FUNC_PACK: begin
          // horner from the top used digit, clamped just past 32 bits
          acc = 0;
          for (k = len - 1; k > 0; k--) begin
            acc = (acc + d[k]) * r[k-1];
            if (acc > NUM_MAX) begin
              big = 1'b1;
              acc = NUM_MAX + 1;
            end
          end
          acc = acc + d[0];
          if (acc > NUM_MAX) big = 1'b1;
          e.number = big ? NUM_W'(NUM_MAX) : NUM_W'(acc);
          e.oor    = big | bad;
        end
        FUNC_UNPACK: begin
          t = w.number;
          for (k = 0; k < len - 1; k++) begin
            e.digit[k] = DOUT_W'(t % r[k]);
            t = t / r[k];
          end
          e.oor = (t >= r[len-1]);
          e.digit[len-1] = (t > DIGIT_SAT) ? DOUT_W'(DIGIT_SAT) : DOUT_W'(t);
        end
        FUNC_INC: begin
          // last used digit is least significant, carry runs toward digit 0
          for (k = 0; k < len; k++) s[k] = d[k];
          i = len - 1;
          s[i] = s[i] + 1;
          while (i > 0 && s[i] == r[i]) begin
            s[i]   = 0;
            s[i-1] = s[i-1] + 1;
            i--;
          end
          for (k = 0; k < len; k++) begin
            e.digit[k] = (s[k] > DIGIT_SAT) ? DOUT_W'(DIGIT_SAT) : DOUT_W'(s[k]);
          end
          e.oor = bad;
        end
        FUNC_CHECK: begin
          e.all_max = top;
          e.oor     = bad;
        end
      endcase
      return e;
    endfunction

    function void note_input(conv_word_t w);
      pending_results.insert(pending_results.size(), convert_word(w));
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(conv_result_t got);
      conv_result_t want;
      int           k;
      if (pending_results.size() == 0) begin
        report("result word with nothing outstanding");
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.number !== want.number)
          report($sformatf("number_out got %0h want %0h", got.number, want.number));
        for (k = 0; k < DIGITS; k++) begin
          if (got.digit[k] !== want.digit[k])
            report($sformatf("digit_out_%0d got %0d want %0d", k, got.digit[k],
                             want.digit[k]));
        end
        if (got.all_max !== want.all_max)
          report($sformatf("all_maximal got %b want %b", got.all_max, want.all_max));
        if (got.oor !== want.oor)
          report($sformatf("out_of_range got %b want %b", got.oor, want.oor));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mrc_in_if  in_ch ();
  mrc_out_if out_ch ();

  mrc_scoreboard sb;
  bit            steady = 1'b0;
  int            words_sent = 0;

  mixed_radix_converter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < GAP_PERCENT);
  endfunction

  function automatic conv_word_t make_word(func_t f, logic [NUM_W-1:0] n,
                                           logic [DIN_W-1:0] d0, logic [DIN_W-1:0] d1,
                                           logic [DIN_W-1:0] d2, logic [DIN_W-1:0] d3);
    conv_word_t w;
    w.func     = f;
    w.number   = n;
    w.digit[0] = d0;
    w.digit[1] = d1;
    w.digit[2] = d2;
    w.digit[3] = d3;
    return w;
  endfunction

  function automatic conv_word_t random_word();
    conv_word_t      w;
    longint unsigned span;
    int              k;
    int              mode;
    int              tail_from;
    w.func = func_t'($urandom_range(0, 3));
    span = 1;
    for (k = 0; k < sb.used_len(); k++) span = span * sb.eff_radix(k);
    mode      = $urandom_range(0, 99);
    tail_from = $urandom_range(0, sb.used_len() - 1);
    for (k = 0; k < DIGITS; k++) begin
      if (mode < 60)
        w.digit[k] = DIN_W'($urandom_range(0, 32'(sb.eff_radix(k) - 1)));
      else if (mode < 80)
        // maximal tail drives carry chains on increment
        w.digit[k] = (k >= tail_from) ? DIN_W'(sb.eff_radix(k) - 1)
                                      : DIN_W'($urandom_range(0, 32'(sb.eff_radix(k) - 1)));
      else
        w.digit[k] = DIN_W'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 9))
      0:       w.number = '0;
      1:       w.number = '1;
      2, 3:    w.number = NUM_W'(span - 1);
      4:       w.number = (span > NUM_MAX) ? NUM_W'(NUM_MAX) : NUM_W'(span);
      5, 6:    w.number = $urandom();
      default: w.number = $urandom_range(0, 32'(span - 1));
    endcase
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_radix();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'(1);
      2:       return CFG_DATA_W'(RADIX_MAX);
      3:       return CFG_DATA_W'($urandom_range(257, 511));
      4, 5:    return CFG_DATA_W'($urandom_range(2, 256));
      default: return CFG_DATA_W'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(DIGITS + 1, 7));
      default: return CFG_DATA_W'($urandom_range(1, DIGITS));
    endcase
  endfunction

  task automatic send_word(conv_word_t w);
    while (take_gap()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= w.func;
    in_ch.number_in  <= w.number;
    in_ch.digit_in_0 <= w.digit[0];
    in_ch.digit_in_1 <= w.digit[1];
    in_ch.digit_in_2 <= w.digit[2];
    in_ch.digit_in_3 <= w.digit[3];
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_input(w);
    words_sent++;
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.note_config(idx, data);
  endtask

  task automatic apply_config(logic [CFG_DATA_W-1:0] count,
                              logic [CFG_DATA_W-1:0] r0, logic [CFG_DATA_W-1:0] r1,
                              logic [CFG_DATA_W-1:0] r2, logic [CFG_DATA_W-1:0] r3,
                              bit poke_unused);
    if (poke_unused)
      write_reg(CFG_IDX_W'(int'(REG_RADIX_0) + DIGITS + $urandom_range(0, 2)),
                CFG_DATA_W'($urandom_range(0, 511)));
    write_reg(REG_DIGIT_COUNT, count);
    write_reg(CFG_IDX_W'(int'(REG_RADIX_0) + 0), r0);
    write_reg(CFG_IDX_W'(int'(REG_RADIX_0) + 1), r1);
    write_reg(CFG_IDX_W'(int'(REG_RADIX_0) + 2), r2);
    write_reg(CFG_IDX_W'(int'(REG_RADIX_0) + 3), r3);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    // reset setting: four binary digits
    send_word(make_word(FUNC_PACK,   32'h0,         0,   0, 0,   0));
    send_word(make_word(FUNC_PACK,   32'h0,         1,   1, 1,   1));
    send_word(make_word(FUNC_PACK,   32'h0,       255,   0, 3,   1));
    send_word(make_word(FUNC_UNPACK, 32'h0,         0,   0, 0,   0));
    send_word(make_word(FUNC_UNPACK, 32'd15,        0,   0, 0,   0));
    send_word(make_word(FUNC_UNPACK, 32'hFFFF_FFFF, 0,   0, 0,   0));
    send_word(make_word(FUNC_INC,    32'h0,         1,   1, 1,   1));
    send_word(make_word(FUNC_INC,    32'h0,         0,   0, 0, 255));
    send_word(make_word(FUNC_CHECK,  32'h0,         1,   1, 1,   1));
    send_word(make_word(FUNC_CHECK,  32'h0,         0, 255, 0,   0));
    settle();
    // widest radices everywhere
    apply_config(4, 256, 256, 256, 256, 1'b0);
    send_word(make_word(FUNC_PACK,   32'h0,       255, 255, 255, 255));
    send_word(make_word(FUNC_UNPACK, 32'hFFFF_FFFF, 0,   0,   0,   0));
    send_word(make_word(FUNC_INC,    32'h0,       255, 255, 255, 255));
    send_word(make_word(FUNC_CHECK,  32'h0,       255, 255, 255, 255));
    send_word(make_word(FUNC_PACK,   32'hFFFF_FFFF, 0,   0,   0,   0));
    settle();
    // zero count and zero radix clamp to one; over-range radices clamp to 256
    apply_config(0, 0, 511, 511, 511, 1'b1);
    send_word(make_word(FUNC_UNPACK, 32'h0001_2345, 0,   0,   0,   0));
    send_word(make_word(FUNC_UNPACK, 32'h0,         0,   0,   0,   0));
    send_word(make_word(FUNC_INC,    32'h0,         0,   0,   0,   0));
    send_word(make_word(FUNC_PACK,   32'h0,       200, 255, 255, 255));
    send_word(make_word(FUNC_CHECK,  32'h0,         0, 255, 255, 255));
    settle();
    // oversized count; unit radices make long carry chains
    apply_config(7, 300, 1, 7, 1, 1'b1);
    send_word(make_word(FUNC_INC,    32'h0,         3,   0,   6,   0));
    send_word(make_word(FUNC_UNPACK, 32'hDEAD_BEEF, 0,   0,   0,   0));
    send_word(make_word(FUNC_PACK,   32'h0,       255,   0,   6,   0));
    send_word(make_word(FUNC_CHECK,  32'h0,       255,   0,   6,   0));
    send_word(make_word(FUNC_INC,    32'h0,       255,   0,   6,   0));
    settle();
  endtask

  // result side: ready toggles at random, words checked at the accepting edge
  initial begin
    conv_result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.number   = out_ch.number_out;
        got.digit[0] = out_ch.digit_out_0;
        got.digit[1] = out_ch.digit_out_1;
        got.digit[2] = out_ch.digit_out_2;
        got.digit[3] = out_ch.digit_out_3;
        got.all_max  = out_ch.all_maximal;
        got.oor      = out_ch.out_of_range;
        sb.check_result(got);
      end
      out_ch.ready <= !take_gap();
    end
  end

  initial begin
    int phase;
    int n;
    sb = new();
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_PACK;
    in_ch.number_in  <= '0;
    in_ch.digit_in_0 <= '0;
    in_ch.digit_in_1 <= '0;
    in_ch.digit_in_2 <= '0;
    in_ch.digit_in_3 <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    phase = 0;
    while (words_sent < WORD_TARGET) begin
      apply_config(random_count(), random_radix(), random_radix(), random_radix(),
                   random_radix(), $urandom_range(0, 3) == 0);
      steady = (phase == 3);
      n = $urandom_range(60, 140);
      repeat (n) send_word(random_word());
      settle();
      phase++;
    end
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Regression FAIL");
    $finish;
  end

endmodule
